### rtl/quaternion_vector_rotation_unit_macros.svh
// Assertion helpers for the rotation unit.
`ifndef QUATERNION_VECTOR_ROTATION_UNIT_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QVR_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define QVR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/qvr_pkg.sv
package qvr_pkg;
   localparam int QW      = 16;           // quaternion and point component width
   localparam int PROD_W  = 2 * QW;       // signed component product
   localparam int M2_W    = PROD_W + 1;   // w^2+x^2+y^2+z^2, unsigned
   localparam int R_W     = PROD_W + 2;   // scaled matrix entry, signed
   localparam int TERM_W  = R_W + QW;     // matrix entry times coordinate
   localparam int SUM_W   = TERM_W + 2;   // three-term dot product
   localparam int NUM_W   = SUM_W + 1;    // 2|n| + m2
   localparam int DEN_W   = M2_W + 1;     // 2 m2
   localparam int QUO_W   = 17;           // rounded quotient magnitude
   localparam int OUT_W   = 17;           // Q9.8 result
   localparam int MAT_LAT = 2;
   localparam int XF_LAT  = 2;
   localparam int DIV_LAT = QUO_W + 2;
   localparam int LAT     = MAT_LAT + XF_LAT + DIV_LAT;
   localparam logic signed [OUT_W:0] OUT_MAX = (OUT_W + 1)'(65535);
   localparam logic signed [OUT_W:0] OUT_MIN = -(OUT_W + 1)'(65536);

   typedef struct packed {
      logic [2:0][2:0][R_W-1:0] r;   // r[row][col], two's complement
      logic [2:0][QW-1:0]       p;   // point x, y, z
      logic [M2_W-1:0]          m2;
      logic                     zero;
   } mat_type;

   typedef struct packed {
      logic [2:0][SUM_W-1:0] n;      // rotated point scaled by m2, not yet divided
      logic [M2_W-1:0]       m2;
      logic                  zero;
   } xf_type;
endpackage

### rtl/qvr_if.sv
interface qvr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] rot_w;
   logic [15:0] rot_x;
   logic [15:0] rot_y;
   logic [15:0] rot_z;
   logic [15:0] pt_x;
   logic [15:0] pt_y;
   logic [15:0] pt_z;
   modport source (output valid, rot_w, rot_x, rot_y, rot_z, pt_x, pt_y, pt_z,
                   input ready);
   modport sink (input valid, rot_w, rot_x, rot_y, rot_z, pt_x, pt_y, pt_z,
                 output ready);
endinterface

interface qvr_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] out_x;
   logic [16:0] out_y;
   logic [16:0] out_z;
   logic        zero_quat;
   modport source (output valid, out_x, out_y, out_z, zero_quat, input ready);
   modport sink (input valid, out_x, out_y, out_z, zero_quat, output ready);
endinterface

### rtl/qvr_mat.sv
module qvr_mat
   import qvr_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [QW-1:0] rot_w,
   input  logic signed [QW-1:0] rot_x,
   input  logic signed [QW-1:0] rot_y,
   input  logic signed [QW-1:0] rot_z,
   input  logic [2:0][QW-1:0]   pt,
   output mat_type              mat
);
   logic signed [PROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [PROD_W-1:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic [2:0][QW-1:0]       pt_ff;
   mat_type                  mat_ff, mat_in;

   // stage 1: component products
   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff <= rot_w * rot_w;
         xx_ff <= rot_x * rot_x;
         yy_ff <= rot_y * rot_y;
         zz_ff <= rot_z * rot_z;
         xy_ff <= rot_x * rot_y;
         wz_ff <= rot_w * rot_z;
         xz_ff <= rot_x * rot_z;
         wy_ff <= rot_w * rot_y;
         yz_ff <= rot_y * rot_z;
         wx_ff <= rot_w * rot_x;
         pt_ff <= pt;
      end
   end

   // stage 2: scaled rotation matrix and squared norm
   always_comb begin
      logic signed [R_W-1:0] ww, xx, yy, zz;
      ww = R_W'(ww_ff);
      xx = R_W'(xx_ff);
      yy = R_W'(yy_ff);
      zz = R_W'(zz_ff);
      mat_in.r[0][0] = ww + xx - yy - zz;
      mat_in.r[0][1] = (R_W'(xy_ff) - R_W'(wz_ff)) <<< 1;
      mat_in.r[0][2] = (R_W'(xz_ff) + R_W'(wy_ff)) <<< 1;
      mat_in.r[1][0] = (R_W'(xy_ff) + R_W'(wz_ff)) <<< 1;
      mat_in.r[1][1] = ww - xx + yy - zz;
      mat_in.r[1][2] = (R_W'(yz_ff) - R_W'(wx_ff)) <<< 1;
      mat_in.r[2][0] = (R_W'(xz_ff) - R_W'(wy_ff)) <<< 1;
      mat_in.r[2][1] = (R_W'(yz_ff) + R_W'(wx_ff)) <<< 1;
      mat_in.r[2][2] = ww - xx - yy + zz;
      mat_in.p       = pt_ff;
      mat_in.m2      = M2_W'($unsigned(ww_ff)) + M2_W'($unsigned(xx_ff))
                     + M2_W'($unsigned(yy_ff)) + M2_W'($unsigned(zz_ff));
      mat_in.zero    = (mat_in.m2 == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff <= mat_in;
      end
   end

   assign mat = mat_ff;
endmodule

### rtl/qvr_xform.sv
module qvr_xform
   import qvr_pkg::*;
(
   input  logic    clock,
   input  logic    en,
   input  mat_type mat,
   output xf_type  xf
);
   logic [2:0][2:0][TERM_W-1:0] term_ff, term_in;
   logic [M2_W-1:0]             m2_ff;
   logic                        zero_ff;
   xf_type                      xf_ff, xf_in;

   // stage 3: matrix entry times coordinate
   always_comb begin
      logic signed [TERM_W-1:0] ra, pa;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ra = TERM_W'($signed(mat.r[i][j]));
            pa = TERM_W'($signed(mat.p[j]));
            term_in[i][j] = ra * pa;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
         m2_ff   <= mat.m2;
         zero_ff <= mat.zero;
      end
   end

   // stage 4: row sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xf_in.n[i] = SUM_W'($signed(term_ff[i][0])) + SUM_W'($signed(term_ff[i][1]))
                    + SUM_W'($signed(term_ff[i][2]));
      end
      xf_in.m2   = m2_ff;
      xf_in.zero = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xf_ff <= xf_in;
      end
   end

   assign xf = xf_ff;
endmodule

### rtl/qvr_div.sv
module qvr_div
   import qvr_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  xf_type                  xf,
   output logic [2:0][OUT_W-1:0]   res,
   output logic                    zero
);
   // index s holds the lanes after s quotient bits have been resolved
   logic [2:0][NUM_W-1:0]          rem_ff [0:QUO_W];
   logic [2:0][QUO_W-1:0]          quo_ff [0:QUO_W];
   logic [2:0]                     neg_ff [0:QUO_W];
   logic [DEN_W-1:0]               den_ff [0:QUO_W];
   logic                           zero_ff [0:QUO_W];
   logic [2:0][OUT_W-1:0]          res_ff, res_in;
   logic                           rzero_ff;

   // prep: sign-magnitude, rounding bias folded into the dividend
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            neg_ff[0][l] <= xf.n[l][SUM_W-1];
            rem_ff[0][l] <= (NUM_W'(xf.n[l][SUM_W-1] ? -$signed(xf.n[l])
                                                     : $signed(xf.n[l])) << 1)
                            + NUM_W'(xf.m2);
            quo_ff[0][l] <= '0;
         end
         den_ff[0]  <= {xf.m2, 1'b0};
         zero_ff[0] <= xf.zero;
      end
   end

   // restoring division, one quotient bit per stage, MSB first
   for (genvar s = 0; s < QUO_W; s++) begin : g_bit
      localparam int B = QUO_W - 1 - s;
      logic [2:0][NUM_W-1:0] rem_in;
      logic [2:0]            ge;
      always_comb begin
         logic [NUM_W-1:0] dsh;
         dsh = NUM_W'(den_ff[s]) << B;
         for (int l = 0; l < 3; l++) begin
            ge[l]     = rem_ff[s][l] >= dsh;
            rem_in[l] = ge[l] ? rem_ff[s][l] - dsh : rem_ff[s][l];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 3; l++) begin
               rem_ff[s+1][l] <= rem_in[l];
               quo_ff[s+1][l] <= {quo_ff[s][l][QUO_W-2:0], ge[l]};
               neg_ff[s+1][l] <= neg_ff[s][l];
            end
            den_ff[s+1]  <= den_ff[s];
            zero_ff[s+1] <= zero_ff[s];
         end
      end
   end

   // sign restore, saturation, zero quaternion forcing
   always_comb begin
      logic signed [OUT_W:0] v;
      for (int l = 0; l < 3; l++) begin
         v = $signed({1'b0, quo_ff[QUO_W][l]});
         if (neg_ff[QUO_W][l]) begin
            v = -v;
         end
         if (v > OUT_MAX) begin
            v = OUT_MAX;
         end else if (v < OUT_MIN) begin
            v = OUT_MIN;
         end
         res_in[l] = zero_ff[QUO_W] ? '0 : v[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff   <= res_in;
         rzero_ff <= zero_ff[QUO_W];
      end
   end

   assign res  = res_ff;
   assign zero = rzero_ff;
endmodule

### rtl/quaternion_vector_rotation_unit.sv
// Rotates a Q8.8 point by a quaternion of any nonzero scale, p' = q p q^-1,
// and returns the Q9.8 result rounded to nearest (ties away from zero) and
// saturated. One transfer is taken every cycle unless the result side
// stalls. Between request and result an item passes four stages of
// products, matrix build, matrix-vector products and row sums, one stage
// that takes the sign and folds in the rounding bias, the 17-stage
// restoring divider (one quotient bit per stage) and the output register.
// Instead of a square root, the product with the raw quaternion is divided
// once by |q|^2. A zero quaternion gives a zero vector with zero_quat set.
// When a finished result waits on a stalled result side, the whole pipeline
// holds and the request side is not ready. No state survives between items.
`include "quaternion_vector_rotation_unit_macros.svh"

module quaternion_vector_rotation_unit
   import qvr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   qvr_req_if.sink   req_if,
   qvr_rsp_if.source rsp_if
);
   logic [LAT-1:0]        vld_ff, vld_in;
   logic                  adv;     // pipeline moves this cycle
   logic                  in_xfer;
   mat_type               mat;
   xf_type                xf;
   logic [2:0][OUT_W-1:0] res;
   logic                  zero;
   logic [2:0][QW-1:0]    pt;
   logic                  rsp_vec_zero;

   // global stall: everything advances unless a finished result waits
   assign adv     = rsp_if.ready || !vld_ff[LAT-1];
   assign req_if.ready = adv;
   assign in_xfer = req_if.valid && adv;
   assign vld_in  = {vld_ff[LAT-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign pt = {req_if.pt_z, req_if.pt_y, req_if.pt_x};

   qvr_mat u_mat (
      .clock (clock),
      .en    (adv),
      .rot_w ($signed(req_if.rot_w)),
      .rot_x ($signed(req_if.rot_x)),
      .rot_y ($signed(req_if.rot_y)),
      .rot_z ($signed(req_if.rot_z)),
      .pt    (pt),
      .mat   (mat)
   );

   qvr_xform u_xform (
      .clock (clock),
      .en    (adv),
      .mat   (mat),
      .xf    (xf)
   );

   qvr_div u_div (
      .clock (clock),
      .en    (adv),
      .xf    (xf),
      .res   (res),
      .zero  (zero)
   );

   assign rsp_if.valid     = vld_ff[LAT-1];
   assign rsp_if.out_x     = res[0];
   assign rsp_if.out_y     = res[1];
   assign rsp_if.out_z     = res[2];
   assign rsp_if.zero_quat = zero;

   assign rsp_vec_zero = (res[0] == '0) && (res[1] == '0) && (res[2] == '0);

   `QVR_ASSERT_NOW(a_zero_vec, clock, reset, rsp_if.valid && zero, rsp_vec_zero, "zero quat")
   `QVR_ASSERT_NEXT(a_enter, clock, reset, in_xfer, vld_ff[0], "transfer not tracked")
   `QVR_ASSERT_NEXT(a_hold, clock, reset, !adv, vld_ff == $past(vld_ff), "moved in stall")
endmodule
